FILE: design/cip_pkg.sv
// cip_pkg: shared types, constants and fixed-point helpers of the circle tessellator
// no dependencies; used by the front, queue, back and top level
package cip_pkg;

    localparam int SEGMENTS = 30;
    localparam int FRAC_BITS = 16;
    localparam int UNIT_BITS = 30;
    localparam int TAYLOR_TERMS = 8;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS = UNIT_BITS;
    localparam int K_W = $clog2(SEGMENTS + 1);
    localparam int TAB_W = $clog2(SEGMENTS);
    localparam int MIN_LEN_W = 17;
    localparam int MIN_LEN_RESET = ((1 << FRAC_BITS) + 5000) / 10000;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // taylor term divisors (2n)(2n+1) and (2n-1)(2n), scaled to q30
    localparam longint SIN_DIV_1 = 64'sd6 <<< UNIT_BITS;
    localparam longint SIN_DIV_2 = 64'sd20 <<< UNIT_BITS;
    localparam longint SIN_DIV_3 = 64'sd42 <<< UNIT_BITS;
    localparam longint SIN_DIV_4 = 64'sd72 <<< UNIT_BITS;
    localparam longint SIN_DIV_5 = 64'sd110 <<< UNIT_BITS;
    localparam longint SIN_DIV_6 = 64'sd156 <<< UNIT_BITS;
    localparam longint SIN_DIV_7 = 64'sd210 <<< UNIT_BITS;
    localparam longint SIN_DIV_8 = 64'sd272 <<< UNIT_BITS;
    localparam longint COS_DIV_1 = 64'sd2 <<< UNIT_BITS;
    localparam longint COS_DIV_2 = 64'sd12 <<< UNIT_BITS;
    localparam longint COS_DIV_3 = 64'sd30 <<< UNIT_BITS;
    localparam longint COS_DIV_4 = 64'sd56 <<< UNIT_BITS;
    localparam longint COS_DIV_5 = 64'sd90 <<< UNIT_BITS;
    localparam longint COS_DIV_6 = 64'sd132 <<< UNIT_BITS;
    localparam longint COS_DIV_7 = 64'sd182 <<< UNIT_BITS;
    localparam longint COS_DIV_8 = 64'sd240 <<< UNIT_BITS;

    localparam logic signed [63:0] ONE = 64'sd1 <<< UNIT_BITS;
    localparam logic [63:0] HALF_UNIT = 64'd1 << (UNIT_BITS - 1);
    localparam logic signed [31:0] ONE32 = 32'sh4000_0000;

    typedef struct packed {
        logic [2:0][31:0] ctr;
        logic [30:0]      rad;
        logic [2:0][31:0] iv;
        logic [2:0][31:0] jv;
    } entry_t;

    function automatic logic signed [63:0] round_q30(input logic signed [63:0] x);
        logic [63:0] m;
        logic [63:0] r;
        m = x[63] ? 64'(-x) : 64'(x);
        r = (m + HALF_UNIT) >> UNIT_BITS;
        return x[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] clamp_unit(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > ONE)
            r = ONE32;
        else if (x < -ONE)
            r = -ONE32;
        else
            r = 32'(x);
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (x < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = 32'(x);
        return r;
    endfunction

    // evaluated at elaboration only to build the angle table
    function automatic logic signed [31:0] trig_entry(input int k, input bit want_sin);
        longint num;
        longint q;
        longint r;
        longint a;
        longint a2;
        longint sn;
        longint cs;
        longint t;
        longint c;
        longint s;
        num = 4 * (k % SEGMENTS);
        q = (num / SEGMENTS) % 4;
        r = num % SEGMENTS;
        a = (HALF_PI_Q30 * r + SEGMENTS / 2) / SEGMENTS;
        a2 = (a * a + (64'sd1 <<< (UNIT_BITS - 1))) >>> UNIT_BITS;
        sn = a;
        t = a;
        t = -(t * a2) / SIN_DIV_1; sn = sn + t;
        t = -(t * a2) / SIN_DIV_2; sn = sn + t;
        t = -(t * a2) / SIN_DIV_3; sn = sn + t;
        t = -(t * a2) / SIN_DIV_4; sn = sn + t;
        t = -(t * a2) / SIN_DIV_5; sn = sn + t;
        t = -(t * a2) / SIN_DIV_6; sn = sn + t;
        t = -(t * a2) / SIN_DIV_7; sn = sn + t;
        t = -(t * a2) / SIN_DIV_8; sn = sn + t;
        cs = ONE;
        t = ONE;
        t = -(t * a2) / COS_DIV_1; cs = cs + t;
        t = -(t * a2) / COS_DIV_2; cs = cs + t;
        t = -(t * a2) / COS_DIV_3; cs = cs + t;
        t = -(t * a2) / COS_DIV_4; cs = cs + t;
        t = -(t * a2) / COS_DIV_5; cs = cs + t;
        t = -(t * a2) / COS_DIV_6; cs = cs + t;
        t = -(t * a2) / COS_DIV_7; cs = cs + t;
        t = -(t * a2) / COS_DIV_8; cs = cs + t;
        if (sn > ONE) sn = ONE;
        if (sn < -ONE) sn = -ONE;
        if (cs > ONE) cs = ONE;
        if (cs < -ONE) cs = -ONE;
        if (q == 0) begin
            c = cs;
            s = sn;
        end else if (q == 1) begin
            c = -sn;
            s = cs;
        end else if (q == 2) begin
            c = -cs;
            s = -sn;
        end else begin
            c = sn;
            s = -cs;
        end
        return want_sin ? 32'(s) : 32'(c);
    endfunction

endpackage

FILE: design/cip_circle_if.sv
// cip_circle_if: input channel carrying one circle per item
// no dependencies
interface cip_circle_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic [30:0]        radius;

    modport source(output valid, center_x, center_y, center_z, normal_x, normal_y,
                   normal_z, radius, input ready);
    modport sink(input valid, center_x, center_y, center_z, normal_x, normal_y,
                 normal_z, radius, output ready);
endinterface

FILE: design/cip_vertex_if.sv
// cip_vertex_if: output channel carrying one vertex per item
// no dependencies
interface cip_vertex_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic [4:0]         vertex_index;
    logic               last_vertex;

    modport source(output valid, vertex_x, vertex_y, vertex_z, vertex_index,
                   last_vertex, input ready);
    modport sink(input valid, vertex_x, vertex_y, vertex_z, vertex_index,
                 last_vertex, output ready);
endinterface

FILE: design/cip_front.sv
// cip_front: accepts circles, normalizes the normal and builds the in-plane frame
// depends on cip_pkg and cip_circle_if; pushes frames into the queue
module cip_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [cip_pkg::MIN_LEN_W-1:0]     min_len,
    cip_circle_if.sink                        circle,
    output logic                              push_valid,
    input  logic                              push_ready,
    output cip_pkg::entry_t                   push_data
);

    typedef enum logic [3:0] {
        F_IDLE, F_SQ1, F_SQRT1, F_CHECK1, F_DIV1, F_FRAME, F_SQ2,
        F_SQRT2, F_CHECK2, F_DIV2, F_NORM, F_CROSS, F_PUSH
    } fstate_t;

    fstate_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic hold_valid_reg;

    logic signed [31:0] hold_c_reg [3];
    logic signed [31:0] hold_n_reg [3];
    logic [30:0]        hold_r_reg;

    logic signed [31:0] ctr_reg [3];
    logic [30:0]        rad_reg;
    logic [31:0]        m_reg [3];
    logic               neg_reg [3];
    logic [63:0]        acc_reg;
    logic [63:0]        sq_reg;
    logic [63:0]        x_reg;
    logic [63:0]        res_reg;
    logic [63:0]        bit_reg;
    logic [31:0]        den_reg;
    logic [31:0]        rem_reg [3];
    logic [29:0]        q_reg [3];
    logic               sat_reg [3];
    logic signed [31:0] v_reg [3];
    logic signed [31:0] iv_reg [3];
    logic signed [31:0] jv_reg [3];
    logic signed [63:0] prod_reg;
    logic signed [63:0] prev_reg;

    logic [63:0]        rb;
    logic               sq_ge;
    logic [32:0]        r2 [3];
    logic               div_ge [3];
    logic [31:0]        vmag [3];
    logic signed [31:0] vval [3];
    logic [31:0]        cm [3];
    logic               cn [3];
    logic signed [31:0] xa;
    logic signed [31:0] xb;
    logic [1:0]         jidx;

    assign circle.ready = !hold_valid_reg;
    assign push_valid = (state_reg == F_PUSH);
    assign jidx = 2'(cnt_reg[2:1] - 2'd1);

    always_comb
    begin
        rb = res_reg + bit_reg;
        sq_ge = (x_reg >= rb);
        for (int d = 0; d < 3; d++)
        begin
            r2[d] = {rem_reg[d], 1'b0};
            div_ge[d] = (r2[d] >= {1'b0, den_reg});
            vmag[d] = sat_reg[d] ? 32'h4000_0000 : {2'b00, q_reg[d]};
            vval[d] = neg_reg[d] ? -$signed(vmag[d]) : $signed(vmag[d]);
        end
    end

    always_comb
    begin
        cm[0] = '0; cm[1] = '0; cm[2] = '0;
        cn[0] = 1'b0; cn[1] = 1'b0; cn[2] = 1'b0;
        priority if (vmag[0] <= vmag[1] && vmag[0] <= vmag[2])
        begin
            cm[1] = vmag[2]; cn[1] = neg_reg[2];
            cm[2] = vmag[1]; cn[2] = !neg_reg[1];
        end
        else if (vmag[1] <= vmag[2] && vmag[1] <= vmag[0])
        begin
            cm[0] = vmag[2]; cn[0] = !neg_reg[2];
            cm[2] = vmag[0]; cn[2] = neg_reg[0];
        end
        else
        begin
            cm[0] = vmag[1]; cn[0] = neg_reg[1];
            cm[1] = vmag[0]; cn[1] = !neg_reg[0];
        end
    end

    always_comb
    begin
        unique case (cnt_reg[2:0])
            3'd0: begin xa = v_reg[1]; xb = iv_reg[2]; end
            3'd1: begin xa = v_reg[2]; xb = iv_reg[1]; end
            3'd2: begin xa = v_reg[2]; xb = iv_reg[0]; end
            3'd3: begin xa = v_reg[0]; xb = iv_reg[2]; end
            3'd4: begin xa = v_reg[0]; xb = iv_reg[1]; end
            3'd5: begin xa = v_reg[1]; xb = iv_reg[0]; end
            default: begin xa = '0; xb = '0; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = 5'(cnt_reg + 5'd1);
        unique case (state_reg)
            F_IDLE:
            begin
                cnt_next = '0;
                if (hold_valid_reg)
                    state_next = F_SQ1;
            end
            F_SQ1, F_SQ2:
            begin
                if (cnt_reg == 5'd3)
                begin
                    cnt_next = '0;
                    state_next = (state_reg == F_SQ1) ? F_SQRT1 : F_SQRT2;
                end
            end
            F_SQRT1, F_SQRT2:
            begin
                if (cnt_reg == 5'(cip_pkg::SQRT_STEPS - 1))
                begin
                    cnt_next = '0;
                    state_next = (state_reg == F_SQRT1) ? F_CHECK1 : F_CHECK2;
                end
            end
            F_CHECK1:
            begin
                cnt_next = '0;
                if (res_reg == 64'd0 || res_reg < 64'(min_len))
                    state_next = F_IDLE;
                else
                    state_next = F_DIV1;
            end
            F_CHECK2:
            begin
                cnt_next = '0;
                state_next = (res_reg == 64'd0) ? F_IDLE : F_DIV2;
            end
            F_DIV1, F_DIV2:
            begin
                if (cnt_reg == 5'(cip_pkg::DIV_STEPS - 1))
                begin
                    cnt_next = '0;
                    state_next = (state_reg == F_DIV1) ? F_FRAME : F_NORM;
                end
            end
            F_FRAME:
            begin
                cnt_next = '0;
                state_next = F_SQ2;
            end
            F_NORM:
            begin
                cnt_next = '0;
                state_next = F_CROSS;
            end
            F_CROSS:
            begin
                if (cnt_reg == 5'd6)
                begin
                    cnt_next = '0;
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                cnt_next = '0;
                if (push_ready)
                    state_next = F_IDLE;
            end
            default:
            begin
                cnt_next = '0;
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg <= '0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            if (circle.valid && circle.ready)
                hold_valid_reg <= 1'b1;
            else if (state_reg == F_IDLE)
                hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (circle.valid && circle.ready)
        begin
            hold_c_reg[0] <= circle.center_x;
            hold_c_reg[1] <= circle.center_y;
            hold_c_reg[2] <= circle.center_z;
            hold_n_reg[0] <= circle.normal_x;
            hold_n_reg[1] <= circle.normal_y;
            hold_n_reg[2] <= circle.normal_z;
            hold_r_reg <= circle.radius;
        end
        unique case (state_reg)
            F_IDLE:
            begin
                rad_reg <= hold_r_reg;
                for (int d = 0; d < 3; d++)
                begin
                    ctr_reg[d] <= hold_c_reg[d];
                    neg_reg[d] <= hold_n_reg[d][31];
                    m_reg[d] <= hold_n_reg[d][31] ? 32'(-hold_n_reg[d]) : hold_n_reg[d];
                end
            end
            F_SQ1, F_SQ2:
            begin
                if (cnt_reg != 5'd3)
                    sq_reg <= 64'(m_reg[cnt_reg[1:0]]) * 64'(m_reg[cnt_reg[1:0]]);
                acc_reg <= (cnt_reg == 5'd0) ? 64'd0 : acc_reg + sq_reg;
                if (cnt_reg == 5'd3)
                begin
                    x_reg <= acc_reg + sq_reg;
                    res_reg <= '0;
                    bit_reg <= 64'd1 << 62;
                end
            end
            F_SQRT1, F_SQRT2:
            begin
                if (sq_ge)
                begin
                    x_reg <= x_reg - rb;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            F_CHECK1, F_CHECK2:
            begin
                den_reg <= res_reg[31:0];
                for (int d = 0; d < 3; d++)
                begin
                    sat_reg[d] <= (m_reg[d] >= res_reg[31:0]);
                    rem_reg[d] <= m_reg[d];
                    q_reg[d] <= '0;
                end
            end
            F_DIV1, F_DIV2:
            begin
                for (int d = 0; d < 3; d++)
                begin
                    if (div_ge[d])
                        rem_reg[d] <= 32'(r2[d] - {1'b0, den_reg});
                    else
                        rem_reg[d] <= r2[d][31:0];
                    q_reg[d] <= {q_reg[d][28:0], div_ge[d]};
                end
            end
            F_FRAME:
            begin
                for (int d = 0; d < 3; d++)
                begin
                    v_reg[d] <= vval[d];
                    m_reg[d] <= cm[d];
                    neg_reg[d] <= cn[d];
                end
            end
            F_NORM:
            begin
                for (int d = 0; d < 3; d++)
                    iv_reg[d] <= vval[d];
            end
            F_CROSS:
            begin
                prod_reg <= 64'(xa) * 64'(xb);
                prev_reg <= prod_reg;
                if (cnt_reg == 5'd2 || cnt_reg == 5'd4 || cnt_reg == 5'd6)
                    jv_reg[jidx] <= cip_pkg::clamp_unit(cip_pkg::round_q30(prev_reg - prod_reg));
            end
            F_PUSH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        push_data.rad = rad_reg;
        for (int d = 0; d < 3; d++)
        begin
            push_data.ctr[d] = ctr_reg[d];
            push_data.iv[d] = iv_reg[d];
            push_data.jv[d] = jv_reg[d];
        end
    end

endmodule

FILE: design/cip_queue.sv
// cip_queue: two-entry queue of circle frames between front and back
// depends on cip_pkg
module cip_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  cip_pkg::entry_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output cip_pkg::entry_t pop_data
);

    cip_pkg::entry_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= 2'(count_reg + 2'd1);
            else if (do_pop && !do_push)
                count_reg <= 2'(count_reg - 2'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: design/cip_back.sv
// cip_back: walks the angle table and emits one vertex per cycle per frame while the vertex sink is ready
// depends on cip_pkg and cip_vertex_if; pops frames from the queue
module cip_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  cip_pkg::entry_t pop_data,
    cip_vertex_if.source    vertex
);

    localparam int KW = cip_pkg::K_W;
    localparam int TW = cip_pkg::TAB_W;

    logic signed [31:0] cos_tab [cip_pkg::SEGMENTS];
    logic signed [31:0] sin_tab [cip_pkg::SEGMENTS];

    for (genvar g = 0; g < cip_pkg::SEGMENTS; g++)
    begin : g_tab
        localparam logic signed [31:0] COS_V = cip_pkg::trig_entry(g, 1'b0);
        localparam logic signed [31:0] SIN_V = cip_pkg::trig_entry(g, 1'b1);
        assign cos_tab[g] = COS_V;
        assign sin_tab[g] = SIN_V;
    end

    cip_pkg::entry_t entry_reg;
    logic            entry_valid_reg;
    logic [KW-1:0]   k_reg;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;

    logic signed [63:0] s1_pa_reg [3];
    logic signed [63:0] s1_pb_reg [3];
    logic signed [31:0] s1_c_reg [3];
    logic [30:0]        s1_r_reg;
    logic [KW-1:0]      s1_k_reg;
    logic               s1_l_reg;

    logic signed [31:0] s2_w_reg [3];
    logic signed [31:0] s2_c_reg [3];
    logic [30:0]        s2_r_reg;
    logic [KW-1:0]      s2_k_reg;
    logic               s2_l_reg;

    logic signed [63:0] s3_o_reg [3];
    logic signed [31:0] s3_c_reg [3];
    logic [KW-1:0]      s3_k_reg;
    logic               s3_l_reg;

    logic signed [31:0] out_p_reg [3];
    logic [KW-1:0]      out_k_reg;
    logic               out_l_reg;

    logic               en;
    logic               issue;
    logic               last_k;
    logic [TW-1:0]      kidx;
    logic signed [31:0] cv;
    logic signed [31:0] sv;

    assign en = !out_valid_reg || vertex.ready;
    assign issue = entry_valid_reg && en;
    assign last_k = (k_reg == KW'(cip_pkg::SEGMENTS));
    assign pop_ready = !entry_valid_reg || (issue && last_k);
    assign kidx = last_k ? '0 : TW'(k_reg);
    assign cv = cos_tab[kidx];
    assign sv = sin_tab[kidx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            k_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop_valid && pop_ready)
            begin
                entry_valid_reg <= 1'b1;
                k_reg <= '0;
            end
            else if (issue)
            begin
                if (last_k)
                    entry_valid_reg <= 1'b0;
                else
                    k_reg <= KW'(k_reg + 1'b1);
            end
            if (en)
            begin
                s1_valid_reg <= issue;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
            entry_reg <= pop_data;
        if (en)
        begin
            for (int d = 0; d < 3; d++)
            begin
                s1_pa_reg[d] <= 64'(cv) * 64'($signed(entry_reg.iv[d]));
                s1_pb_reg[d] <= 64'(sv) * 64'($signed(entry_reg.jv[d]));
                s1_c_reg[d] <= $signed(entry_reg.ctr[d]);
                s2_w_reg[d] <= cip_pkg::clamp_unit(
                    cip_pkg::round_q30(s1_pa_reg[d] + s1_pb_reg[d]));
                s2_c_reg[d] <= s1_c_reg[d];
                s3_o_reg[d] <= 64'($signed({1'b0, s2_r_reg})) * 64'(s2_w_reg[d]);
                s3_c_reg[d] <= s2_c_reg[d];
                out_p_reg[d] <= cip_pkg::sat32(
                    64'(s3_c_reg[d]) + cip_pkg::round_q30(s3_o_reg[d]));
            end
            s1_r_reg <= entry_reg.rad;
            s1_k_reg <= k_reg;
            s1_l_reg <= last_k;
            s2_r_reg <= s1_r_reg;
            s2_k_reg <= s1_k_reg;
            s2_l_reg <= s1_l_reg;
            s3_k_reg <= s2_k_reg;
            s3_l_reg <= s2_l_reg;
            out_k_reg <= s3_k_reg;
            out_l_reg <= s3_l_reg;
        end
    end

    assign vertex.valid = out_valid_reg;
    assign vertex.vertex_x = out_p_reg[0];
    assign vertex.vertex_y = out_p_reg[1];
    assign vertex.vertex_z = out_p_reg[2];
    assign vertex.vertex_index = 5'(out_k_reg);
    assign vertex.last_vertex = out_l_reg;

endmodule

FILE: design/circle_in_plane_tessellator_unit.sv
// circle_in_plane_tessellator_unit: top level, configuration register and wiring
// depends on cip_pkg, cip_circle_if, cip_vertex_if, cip_front, cip_queue, cip_back
//
// Takes one circle (centre, normal, radius in Q16.16) per item and emits 31 vertices
// around it, the last repeating the first and flagged by last_vertex. Circles whose
// normal length is below min_normal_length (APB register at byte address 0, reset 7)
// or is zero give no vertices. The front sequencer works through each circle in turn:
// two 32-step square roots, two 30-step division passes with three dividers in
// parallel, one multiplier for the squares and one for the cross product. A two-entry
// queue separates it from the back, which emits one vertex per cycle while the vertex
// sink is ready, through a four-stage pipeline, so the sustained circle rate is set
// by the front square root and divider iterations.
module circle_in_plane_tessellator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    cip_circle_if.sink  circle,
    cip_vertex_if.source vertex
);

    logic [cip_pkg::MIN_LEN_W-1:0] min_len_reg;
    logic            push_valid;
    logic            push_ready;
    cip_pkg::entry_t push_data;
    logic            pop_valid;
    logic            pop_ready;
    cip_pkg::entry_t pop_data;

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? 32'(min_len_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_len_reg <= cip_pkg::MIN_LEN_W'(cip_pkg::MIN_LEN_RESET);
        else if (psel && penable && pwrite && pready && paddr == 3'd0)
            min_len_reg <= pwdata[cip_pkg::MIN_LEN_W-1:0];
    end

    cip_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .min_len    (min_len_reg),
        .circle     (circle),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    cip_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    cip_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .vertex    (vertex)
    );

endmodule
